>>> rtl/irap_pkg.sv
// Package for the interval range add peak block.
// Holds the input item type and the fixed field widths; no dependencies.
package irap_pkg;

   // Fixed widths of the item and result fields.
   localparam int START_W  = 10;
   localparam int WEIGHT_W = 8;
   localparam int PEAK_W   = 16;

   // One interval as taken from the request channel.
   typedef struct packed {
      logic [START_W-1:0]  start_slot;
      logic [START_W-1:0]  end_slot;
      logic [WEIGHT_W-1:0] weight;
   } item_type;

endpackage

>>> rtl/irap_cell.sv
// One slot counter of the circulating load ring.
// Standalone; no package dependencies.
module irap_cell #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] value_ff;

   // Take the neighbor's value whenever the ring advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else if (shift_en) begin
         value_ff <= data_in;
      end
   end

   assign data_out = value_ff;

endmodule

>>> rtl/irap_update.sv
// Update unit at the head of the ring: saturating add, range check, peak track.
// Depends on irap_pkg for the item type and field widths.
module irap_update
   import irap_pkg::*;
#(
   parameter int SLOT_W      = 10,
   parameter int COUNT_WIDTH = 16
) (
   input  logic [SLOT_W-1:0]      slot_idx,
   input  item_type               item,
   input  logic [COUNT_WIDTH-1:0] slot_val,
   input  logic [COUNT_WIDTH-1:0] peak_val,
   input  logic                   sat_val,
   output logic [COUNT_WIDTH-1:0] slot_new,
   output logic [COUNT_WIDTH-1:0] peak_new,
   output logic                   sat_new
);

   localparam int CMP_W = (SLOT_W > START_W) ? SLOT_W : START_W;

   logic [CMP_W-1:0]       idx_ext;
   logic [CMP_W-1:0]       start_ext;
   logic [CMP_W-1:0]       end_ext;
   logic                   in_range;
   logic [COUNT_WIDTH:0]   sum;
   logic                   hit_top;
   logic [COUNT_WIDTH-1:0] added;

   // The slot is covered when it lies between start and end inclusive.
   // Slots past the timeline never reach this unit, so the end needs no clipping.
   assign idx_ext   = CMP_W'(slot_idx);
   assign start_ext = CMP_W'(item.start_slot);
   assign end_ext   = CMP_W'(item.end_slot);
   assign in_range  = (idx_ext >= start_ext) && (idx_ext <= end_ext);

   // Saturating add: reaching the all-ones value counts as saturation.
   assign sum     = {1'b0, slot_val} + (COUNT_WIDTH + 1)'(item.weight);
   assign hit_top = sum[COUNT_WIDTH] | (&sum[COUNT_WIDTH-1:0]);
   assign added   = hit_top ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];

   // Only covered slots change and take part in the peak.
   always_comb begin
      slot_new = slot_val;
      peak_new = peak_val;
      sat_new  = sat_val;
      if (in_range) begin
         slot_new = added;
         sat_new  = sat_val | hit_top;
         if (added > peak_val) begin
            peak_new = added;
         end
      end
   end

endmodule

>>> rtl/interval_range_add_peak.sv
// Top level of the interval range add peak block: ring of slot cells plus head unit.
// Depends on irap_pkg, irap_cell and irap_update.
//
//   Channel  Direction  Ports                                          Handshake
//   req      in         req_start_slot, req_end_slot, req_weight       req_valid / req_ready
//   rsp      out        rsp_peak_load, rsp_saturated                   rsp_valid / rsp_ready
//
// The slot counters sit in a ring of TIME_SLOTS cells that rotates one place per
// cycle past a single update unit while busy, unless the final step is held, so an
// item visits every slot once, and no new item is taken until its final step.
// The result is loaded into the output register on the final step.
// Reset clears every cell, the peak and the saturation flag.
// A result still waiting on rsp_ready holds the ring before its final step only.
module interval_range_add_peak
   import irap_pkg::*;
#(
   parameter int TIME_SLOTS  = 1024,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [START_W-1:0]  req_start_slot,
   input  logic [START_W-1:0]  req_end_slot,
   input  logic [WEIGHT_W-1:0] req_weight,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PEAK_W-1:0]   rsp_peak_load,
   output logic                rsp_saturated
);

   localparam int SLOT_W = (TIME_SLOTS > 1) ? $clog2(TIME_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIME_SLOTS - 1);

   logic                   busy_ff, busy_in;
   logic [SLOT_W-1:0]      cnt_ff, cnt_in;
   item_type               item_ff;
   logic [COUNT_WIDTH-1:0] peak_ff, peak_in;
   logic                   sat_ff, sat_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PEAK_W-1:0]      rsp_peak_ff;
   logic                   rsp_sat_ff;

   logic                   req_fire;
   logic                   last_step;
   logic                   step_go;
   logic [COUNT_WIDTH-1:0] ring [TIME_SLOTS];
   logic [COUNT_WIDTH-1:0] head_new;
   logic [PEAK_W+COUNT_WIDTH-1:0] peak_ext;

   assign req_ready = ~busy_ff;
   assign req_fire  = req_valid & req_ready;
   assign last_step = (cnt_ff == LAST_SLOT);

   // The ring advances every busy cycle, except that the final step waits
   // until the output register is free.
   assign step_go = busy_ff & ~(last_step & rsp_valid_ff & ~rsp_ready);

   // Ring of slot cells; the last cell feeds the update unit, which feeds cell 0.
   for (genvar i = 0; i < TIME_SLOTS; i++) begin : g_cell
      if (i == 0) begin : g_head
         irap_cell #(.WIDTH(COUNT_WIDTH)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (step_go),
            .data_in  (head_new),
            .data_out (ring[i])
         );
      end else begin : g_body
         irap_cell #(.WIDTH(COUNT_WIDTH)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (step_go),
            .data_in  (ring[i-1]),
            .data_out (ring[i])
         );
      end
   end

   // The slot leaving the ring on step n is slot n.
   irap_update #(
      .SLOT_W      (SLOT_W),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_update (
      .slot_idx (cnt_ff),
      .item     (item_ff),
      .slot_val (ring[TIME_SLOTS-1]),
      .peak_val (peak_ff),
      .sat_val  (sat_ff),
      .slot_new (head_new),
      .peak_new (peak_in),
      .sat_new  (sat_in)
   );

   // Sequencing of one item through all slots.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (req_fire) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (step_go) begin
         cnt_in = cnt_ff + SLOT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   // The output register fills on the final step and empties on rsp_ready.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_go && last_step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         peak_ff      <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_go) begin
            peak_ff <= peak_in;
            sat_ff  <= sat_in;
         end
      end
   end

   // The peak field carries the low bits of the running peak.
   assign peak_ext = {{PEAK_W{1'b0}}, peak_in};

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.start_slot <= req_start_slot;
         item_ff.end_slot   <= req_end_slot;
         item_ff.weight     <= req_weight;
      end
      if (step_go && last_step) begin
         rsp_peak_ff <= peak_ext[PEAK_W-1:0];
         rsp_sat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_peak_load = rsp_peak_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

>>> dv/interval_range_add_peak_checker.sv
// Checker for the interval range add peak block: watches both channels,
// keeps its own slot timeline and compares every result with the prediction.
// Depends on irap_pkg for the field widths.
module interval_range_add_peak_checker
   import irap_pkg::*;
#(
   parameter int TIME_SLOTS  = 1024,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [START_W-1:0]  req_start_slot,
   input  logic [START_W-1:0]  req_end_slot,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [PEAK_W-1:0]   rsp_peak_load,
   input  logic                rsp_saturated,
   output int                  fail_count,
   output int                  pending
);

   typedef struct {
      logic [PEAK_W-1:0] peak_load;
      logic              saturated;
   } load_report_type;

   localparam longint COUNT_MAX = (longint'(1) << COUNT_WIDTH) - 1;

   // Predicted timeline, running peak and sticky saturation flag.
   logic [COUNT_WIDTH-1:0] slot_total [TIME_SLOTS];
   logic [COUNT_WIDTH-1:0] peak_total;
   logic                   sat_seen;
   load_report_type        reports_due [$];

   // Adds one interval to the timeline and queues the report it should produce.
   task automatic load_interval(input logic [START_W-1:0] first,
                                input logic [START_W-1:0] last_in,
                                input logic [WEIGHT_W-1:0] amount);
      int              last;
      longint          total;
      load_report_type report;
      last = int'(last_in);
      // Slots past the end of the timeline are dropped.
      if (last > TIME_SLOTS - 1)
         last = TIME_SLOTS - 1;
      // A start after the end leaves the loop empty and adds nothing.
      for (int s = int'(first); s <= last; s++) begin
         total = longint'(slot_total[s]) + longint'(amount);
         if (total >= COUNT_MAX) begin
            total    = COUNT_MAX;
            sat_seen = 1'b1;
         end
         slot_total[s] = COUNT_WIDTH'(total);
         if (slot_total[s] > peak_total)
            peak_total = slot_total[s];
      end
      report.peak_load = PEAK_W'(peak_total);
      report.saturated = sat_seen;
      reports_due.push_back(report);
   endtask

   // Results are checked before requests are taken; an item's result never
   // leaves on the edge that accepts the item.
   always @(posedge clock) begin
      load_report_type want;
      if (reset) begin
         foreach (slot_total[s])
            slot_total[s] = '0;
         peak_total = '0;
         sat_seen   = 1'b0;
         reports_due.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (reports_due.size() == 0) begin
               $error("result with no item outstanding: peak_load %0d, saturated %0b",
                      rsp_peak_load, rsp_saturated);
               fail_count++;
            end else begin
               want = reports_due.pop_front();
               if (rsp_peak_load !== want.peak_load) begin
                  $error("peak_load mismatch: expected %0d, actual %0d",
                         want.peak_load, rsp_peak_load);
                  fail_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated mismatch: expected %0b, actual %0b",
                         want.saturated, rsp_saturated);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            load_interval(req_start_slot, req_end_slot, req_weight);
      end
      pending <= reports_due.size();
   end

endmodule

>>> dv/interval_range_add_peak_tb.sv
// Testbench top for the interval range add peak block: clock, reset, interval
// stimulus, result-side stalls, watchdog and verdict.
// Depends on irap_pkg, interval_range_add_peak and interval_range_add_peak_checker.
module interval_range_add_peak_tb;
   import irap_pkg::*;

   localparam int TIME_SLOTS   = 1024;
   localparam int COUNT_WIDTH  = 16;
   localparam int RANDOM_ITEMS = 556;
   localparam int HOT_SLOT     = 512;
   localparam int LAST_SLOT    = TIME_SLOTS - 1;
   localparam int DRAIN_CYCLES = 1100;
   localparam int QUIET_LIMIT  = 5000;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [START_W-1:0]  req_start_slot;
   logic [START_W-1:0]  req_end_slot;
   logic [WEIGHT_W-1:0] req_weight;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [PEAK_W-1:0]   rsp_peak_load;
   logic                rsp_saturated;

   int fail_count;
   int pending;
   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;
   int rsp_hold;
   int quiet_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   interval_range_add_peak #(
      .TIME_SLOTS (TIME_SLOTS),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_start_slot(req_start_slot),
      .req_end_slot  (req_end_slot),
      .req_weight    (req_weight),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_peak_load (rsp_peak_load),
      .rsp_saturated (rsp_saturated)
   );

   interval_range_add_peak_checker #(
      .TIME_SLOTS (TIME_SLOTS),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) load_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_start_slot(req_start_slot),
      .req_end_slot  (req_end_slot),
      .req_weight    (req_weight),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_peak_load (rsp_peak_load),
      .rsp_saturated (rsp_saturated),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   // Offers one interval, after a random gap when send_idle is set, and returns on the edge that takes it.
   task automatic send_interval(input int first, input int last, input int amount);
      int gap;
      gap = send_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_start_slot <= START_W'(first);
      req_end_slot   <= START_W'(last);
      req_weight     <= WEIGHT_W'(amount);
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Draws one random interval. Most of them pile weight on a hot slot so that
   // its counter saturates partway through the run.
   task automatic send_random_interval();
      int kind;
      int first;
      int last;
      int amount;
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
         first  = $urandom_range(0, HOT_SLOT);
         last   = $urandom_range(HOT_SLOT, LAST_SLOT);
         amount = $urandom_range(192, 255);
      end else if (kind < 80) begin
         first  = $urandom_range(0, LAST_SLOT);
         last   = first + $urandom_range(0, 31);
         if (last > LAST_SLOT)
            last = LAST_SLOT;
         amount = $urandom_range(0, 255);
      end else if (kind < 90) begin
         // Start after end.
         first  = $urandom_range(1, LAST_SLOT);
         last   = $urandom_range(0, first - 1);
         amount = $urandom_range(0, 255);
      end else begin
         first  = $urandom_range(0, LAST_SLOT);
         last   = $urandom_range(0, LAST_SLOT);
         amount = $urandom_range(0, 255);
      end
      send_interval(first, last, amount);
   endtask

   // Result side: after each accepted result, drop ready for a random stall when
   // recv_idle is set; the stall counts down once the next result shows up.
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_ready <= 1'b1;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         n = recv_idle ? $urandom_range(0, 9) : 0;
         rsp_ready <= (n == 0);
         rsp_hold  <= n;
      end else if (rsp_valid && !rsp_ready) begin
         if (rsp_hold <= 1)
            rsp_ready <= 1'b1;
         if (rsp_hold > 0)
            rsp_hold <= rsp_hold - 1;
      end
   end

   // Watchdog: too long without any item moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_start_slot <= '0;
      req_end_slot   <= '0;
      req_weight     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed intervals: field extremes, single slots, full span,
      // zero weight and start after end.
      send_interval(0, 0, 255);
      send_interval(LAST_SLOT, LAST_SLOT, 255);
      send_interval(0, LAST_SLOT, 0);
      send_interval(5, 3, 100);
      send_interval(LAST_SLOT, 0, 255);
      send_interval(0, LAST_SLOT, 255);
      send_interval(HOT_SLOT, HOT_SLOT, 1);
      send_interval(0, LAST_SLOT, 1);
      send_interval(1, LAST_SLOT - 1, 128);
      send_interval(10, 10, 0);
      send_interval(341, 682, 85);
      send_interval(682, 341, 170);
      send_interval(1000, LAST_SLOT, 255);
      send_interval(0, 9, 255);
      send_interval(LAST_SLOT, LAST_SLOT, 0);
      send_interval(HOT_SLOT, HOT_SLOT - 1, 255);
      send_interval(0, 0, 0);
      send_interval(HOT_SLOT, LAST_SLOT, 254);
      send_interval(0, HOT_SLOT, 127);
      send_interval(HOT_SLOT + 1, HOT_SLOT + 1, 255);

      // Random intervals in segments, some with idling and some without.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) begin
            send_idle = ($urandom_range(0, 2) != 0);
            recv_idle = ($urandom_range(0, 2) != 0);
         end
         // Halfway through, let the block drain completely before going on.
         if (i == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            wait (pending == 0);
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
         send_random_interval();
      end
      req_valid <= 1'b0;

      // Drain, then watch a while longer for stray results.
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> interval_range_add_peak.f
rtl/irap_pkg.sv
rtl/irap_cell.sv
rtl/irap_update.sv
rtl/interval_range_add_peak.sv
dv/interval_range_add_peak_checker.sv
dv/interval_range_add_peak_tb.sv
